// File: src/utf8_stream_decoder_macros.svh
// Assertion macros shared by the utf8_stream_decoder RTL.
// Needs a clock named clk and an active-low reset named arst_n in the using scope.
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH
`ifndef SYNTHESIS
// Holds at every clock edge outside reset.
`define UTF8SD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Antecedent implies consequent in the cycle after.
`define UTF8SD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define UTF8SD_ASSERT(label, prop, msg)
`define UTF8SD_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: src/utf8sd_pkg.sv
// Types and constants of the UTF-8 stream decoder.
// No dependencies; used by the interfaces, utf8sd_step and utf8_stream_decoder.
`default_nettype none

package utf8sd_pkg;

	localparam int CpW     = 31;
	localparam int StatusW = 3;
	localparam int CntW    = 3;

	localparam logic [CpW-1:0] MaxCpReset = 31'h0000_FFFF;

	typedef enum logic [StatusW-1:0] {
		ST_CHAR     = 3'd0,
		ST_BAD_LEAD = 3'd1,
		ST_BAD_CONT = 3'd2,
		ST_OVERLONG = 3'd3,
		ST_NUL      = 3'd4,
		ST_LIMIT    = 3'd5
	} status_t;

	// Decoder state carried from one byte to the next.
	typedef struct packed {
		logic [CpW-1:0]  acc;
		logic [CntW-1:0] remain;
		logic [CntW-1:0] seqlen;
		logic            second;
		logic            stopped;
	} seq_state_t;

	typedef struct packed {
		logic           valid;
		logic [CpW-1:0] code_point;
		status_t        status;
	} step_result_t;

endpackage

`default_nettype wire

// File: src/utf8sd_if.sv
// Valid/ready channel interfaces of the UTF-8 stream decoder.
// Depends on utf8sd_pkg for field widths.
`default_nettype none

interface utf8sd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_req;
	modport source (output valid, data_byte, start_req, input ready);
	modport sink (input valid, data_byte, start_req, output ready);
endinterface

interface utf8sd_cp_if;
	logic                             valid;
	logic                             ready;
	logic [utf8sd_pkg::CpW-1:0]       code_point;
	logic [utf8sd_pkg::StatusW-1:0]   status;
	modport source (output valid, code_point, status, input ready);
	modport sink (input valid, code_point, status, output ready);
endinterface

interface utf8sd_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [utf8sd_pkg::CpW-1:0] max_code_point;
	modport source (output valid, max_code_point, input ready);
	modport sink (input valid, max_code_point, output ready);
endinterface

`default_nettype wire

// File: src/utf8sd_step.sv
// Next-state and result logic for one byte of the UTF-8 stream decoder.
// Purely combinational; depends on utf8sd_pkg.
`default_nettype none

module utf8sd_step (
	input  utf8sd_pkg::seq_state_t   cur,
	input  logic [7:0]               b,
	input  logic                     start,
	input  logic [utf8sd_pkg::CpW-1:0] max_cp,
	output utf8sd_pkg::seq_state_t   nxt,
	output utf8sd_pkg::step_result_t res
);

	logic [2:0]                   lead_len;
	logic [7:0]                   lead_mask;
	logic [5:0]                   need;
	logic [utf8sd_pkg::CpW-1:0]   acc_n;
	logic [utf8sd_pkg::CpW-1:0]   cand;
	logic                         fin;
	logic                         halt_en;
	utf8sd_pkg::status_t          halt_code;

	// Lead byte classes, legacy forms up to six bytes
	always_comb begin
		if (b[7] == 1'b0)                 lead_len = 3'd1;
		else if (b[7:5] == 3'b110)        lead_len = 3'd2;
		else if (b[7:4] == 4'b1110)       lead_len = 3'd3;
		else if (b[7:3] == 5'b11110)      lead_len = 3'd4;
		else if (b[7:2] == 6'b111110)     lead_len = 3'd5;
		else if (b[7:1] == 7'b1111110)    lead_len = 3'd6;
		else                              lead_len = 3'd0;
	end

	always_comb begin
		case (lead_len)
			3'd2:    lead_mask = 8'h1F;
			3'd3:    lead_mask = 8'h0F;
			3'd4:    lead_mask = 8'h07;
			3'd5:    lead_mask = 8'h03;
			3'd6:    lead_mask = 8'h01;
			default: lead_mask = 8'h7F;
		endcase
	end

	// Top payload bits of the first continuation that must not all be zero
	always_comb begin
		case (cur.seqlen)
			3'd3:    need = 6'h20;
			3'd4:    need = 6'h30;
			3'd5:    need = 6'h38;
			default: need = 6'h3C;
		endcase
	end

	always_comb begin
		nxt       = cur;
		res       = '0;
		fin       = 1'b0;
		cand      = '0;
		halt_en   = 1'b0;
		halt_code = utf8sd_pkg::ST_CHAR;
		acc_n     = {cur.acc[utf8sd_pkg::CpW-7:0], b[5:0]};

		if (start) begin
			nxt = '0;
		end

		if (!nxt.stopped) begin
			if (nxt.remain == '0) begin
				if (lead_len == 3'd0) begin
					halt_en   = 1'b1;
					halt_code = utf8sd_pkg::ST_BAD_LEAD;
				end else if (lead_len == 3'd2 && b[4:1] == 4'd0) begin
					halt_en   = 1'b1;
					halt_code = utf8sd_pkg::ST_OVERLONG;
				end else if (lead_len == 3'd1) begin
					fin  = 1'b1;
					cand = {{(utf8sd_pkg::CpW-7){1'b0}}, b[6:0]};
				end else begin
					nxt.acc    = {{(utf8sd_pkg::CpW-8){1'b0}}, b & lead_mask};
					nxt.remain = lead_len - 3'd1;
					nxt.seqlen = lead_len;
					nxt.second = (lead_len >= 3'd3);
				end
			end else if (b[7:6] != 2'b10) begin
				halt_en   = 1'b1;
				halt_code = utf8sd_pkg::ST_BAD_CONT;
			end else begin
				nxt.second = 1'b0;
				if (cur.second && cur.acc == '0 && (b[5:0] & need) == 6'd0) begin
					halt_en   = 1'b1;
					halt_code = utf8sd_pkg::ST_OVERLONG;
				end else if (cur.remain == 3'd1) begin
					fin  = 1'b1;
					cand = acc_n;
				end else begin
					nxt.acc    = acc_n;
					nxt.remain = cur.remain - 3'd1;
				end
			end
		end

		if (fin) begin
			if (cand == '0) begin
				halt_en   = 1'b1;
				halt_code = utf8sd_pkg::ST_NUL;
			end else if (cand > max_cp) begin
				halt_en   = 1'b1;
				halt_code = utf8sd_pkg::ST_LIMIT;
			end else begin
				nxt            = '0;
				res.valid      = 1'b1;
				res.code_point = cand;
				res.status     = utf8sd_pkg::ST_CHAR;
			end
		end

		if (halt_en) begin
			nxt            = '0;
			nxt.stopped    = 1'b1;
			res.valid      = 1'b1;
			res.code_point = '0;
			res.status     = halt_code;
		end
	end

endmodule

`default_nettype wire

// File: src/utf8_stream_decoder.sv
// UTF-8 stream decoder top level: input register, decode step, result register.
// Depends on utf8sd_pkg, utf8sd_if, utf8sd_step and utf8_stream_decoder_macros.svh.
//
// Usage:
//   stream : byte channel (data_byte, start_req), valid/ready, one byte an item.
//   chars  : result channel (code_point, status); status 0 is a decoded
//            character, any other status a stop report with code_point 0.
//   cfg    : write channel for max_code_point; always ready; write only while
//            the decoder is idle.
// A byte is taken into the input register, decoded in the next cycle and its
// result (if any) lands in the result register when that slot is free or being
// emptied. One byte per cycle is sustained while chars is ready; the decode
// logic between the two registers sets that rate.
// After a stop report, bytes are swallowed without result until one arrives
// with start_req set; start_req also drops any partial sequence silently.
// Reset clears the sequence state and the valid flags of both registers and
// sets max_code_point to 0xFFFF. When chars stalls, the result register holds,
// the input register holds its byte, and stream.ready falls once both are full.
`default_nettype none
`include "utf8_stream_decoder_macros.svh"

module utf8_stream_decoder (
	input  logic              clk,
	input  logic              arst_n,
	utf8sd_byte_if.sink       stream,
	utf8sd_cp_if.source       chars,
	utf8sd_cfg_if.sink        cfg
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;

	// sequence state and limit
	utf8sd_pkg::seq_state_t     state_q;
	logic [utf8sd_pkg::CpW-1:0] max_cp_q;

	// result register
	logic                           out_valid_q;
	logic [utf8sd_pkg::CpW-1:0]     out_cp_q;
	utf8sd_pkg::status_t            out_status_q;

	utf8sd_pkg::seq_state_t   state_n;
	utf8sd_pkg::step_result_t res;
	logic                     advance;
	logic                     in_acc;

	// A byte moves on when the result slot is free or being emptied now.
	assign advance      = valid_s1 && (!out_valid_q || chars.ready);
	assign stream.ready = !valid_s1 || advance;
	assign in_acc       = stream.valid && stream.ready;
	assign cfg.ready    = 1'b1;

	assign chars.valid      = out_valid_q;
	assign chars.code_point = out_cp_q;
	assign chars.status     = out_status_q;

	utf8sd_step u_step (
		.cur    (state_q),
		.b      (byte_s1),
		.start  (start_s1),
		.max_cp (max_cp_q),
		.nxt    (state_n),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1  <= stream.data_byte;
			start_s1 <= stream.start_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			max_cp_q <= utf8sd_pkg::MaxCpReset;
		end else begin
			if (advance) begin
				state_q <= state_n;
			end
			if (cfg.valid) begin
				max_cp_q <= cfg.max_code_point;
			end
		end
	end

	// Result register: loads on a produced result, drains on chars.ready.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (chars.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			out_cp_q     <= res.code_point;
			out_status_q <= res.status;
		end
	end

	`UTF8SD_ASSERT(a_stop_cp_zero, !out_valid_q || out_status_q == utf8sd_pkg::ST_CHAR || out_cp_q == '0, "stop report with nonzero code point")
	`UTF8SD_ASSERT(a_remain_lt_len, state_q.remain == '0 || state_q.seqlen > state_q.remain, "remaining count not below sequence length")
	`UTF8SD_ASSERT(a_stop_clean, !state_q.stopped || (state_q.remain == '0 && state_q.acc == '0), "partial sequence kept while stopped")
	`UTF8SD_ASSERT_NEXT(a_stopped_silent, advance && state_q.stopped && !start_s1, $stable(state_q) && $stable(out_cp_q), "stopped decoder changed state")
	`UTF8SD_ASSERT_NEXT(a_result_held, out_valid_q && !chars.ready, out_valid_q && $stable(out_cp_q) && $stable(out_status_q), "stalled result lost")

endmodule

`default_nettype wire
